### rtl/core/aomt_pkg.sv
// Shared types and constants of the active offset maximum table.
package aomt_pkg;

   // Table geometry and actuator id range.
   localparam int TableDepth   = 16;
   localparam int NumActuators = 32;
   localparam int CountW       = $clog2(TableDepth + 1);

   // Field widths of one request and one response.
   localparam int OpW  = 2;
   localparam int IdW  = 6;
   localparam int CmdW = 8;
   localparam int OfsW = 16;
   localparam int StW  = 2;

   // Offset lanes, in the order left, right, front, back.
   localparam int NumOfs    = 4;
   localparam int OfsLeft   = 0;
   localparam int OfsRight  = 1;
   localparam int OfsFront  = 2;
   localparam int OfsBack   = 3;

   // Request operation codes.
   localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
   localparam logic [OpW-1:0] OP_DEACT = 2'd1;
   localparam logic [OpW-1:0] OP_CMD   = 2'd2;

   // Response status codes.
   localparam logic [StW-1:0] ST_OK      = 2'd0;
   localparam logic [StW-1:0] ST_FULL    = 2'd1;
   localparam logic [StW-1:0] ST_UNKNOWN = 2'd2;

   typedef logic [NumOfs-1:0][OfsW-1:0] offs_type;

   // Data written into one cell on a load.
   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [CmdW-1:0] cmd;
      offs_type        offs;
   } entry_type;

   // Token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic            valid;
      logic            command;  // activate a match and gather maxima
      logic [IdW-1:0]  id;
      logic [CmdW-1:0] cmd;
      logic            found;    // an earlier cell already took the match
      offs_type        maxs;     // running maxima over active cells so far
   } token_type;

endpackage

### rtl/core/aomt_req_if.sv
// Request channel of the active offset maximum table.
interface aomt_req_if;
   logic                         valid;
   logic                         ready;
   logic [aomt_pkg::OpW-1:0]     op;
   logic [aomt_pkg::IdW-1:0]     actuator_id;
   logic [aomt_pkg::CmdW-1:0]    command_code;
   logic [aomt_pkg::OfsW-1:0]    left_offset;
   logic [aomt_pkg::OfsW-1:0]    right_offset;
   logic [aomt_pkg::OfsW-1:0]    front_offset;
   logic [aomt_pkg::OfsW-1:0]    back_offset;

   modport source (
      output valid, op, actuator_id, command_code,
             left_offset, right_offset, front_offset, back_offset,
      input  ready
   );
   modport sink (
      input  valid, op, actuator_id, command_code,
             left_offset, right_offset, front_offset, back_offset,
      output ready
   );
endinterface

### rtl/core/aomt_rsp_if.sv
// Response channel of the active offset maximum table.
interface aomt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [aomt_pkg::StW-1:0]     status;
   logic [aomt_pkg::OfsW-1:0]    total_left;
   logic [aomt_pkg::OfsW-1:0]    total_right;
   logic [aomt_pkg::OfsW-1:0]    total_front;
   logic [aomt_pkg::OfsW-1:0]    total_back;
   logic                         totals_changed;
   logic                         entry_matched;

   modport source (
      output valid, status, total_left, total_right, total_front, total_back,
             totals_changed, entry_matched,
      input  ready
   );
   modport sink (
      input  valid, status, total_left, total_right, total_front, total_back,
             totals_changed, entry_matched,
      output ready
   );
endinterface

### rtl/core/aomt_cell.sv
// One table entry of the row, with its stage of the walking token.
module aomt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  aomt_pkg::entry_type   wr_data,
   input  aomt_pkg::token_type   tok_in,
   output aomt_pkg::token_type   tok_out
);

   logic                          used_ff;
   logic                          used_in;
   logic                          active_ff;
   logic                          active_in;
   logic [aomt_pkg::IdW-1:0]      id_ff;
   logic [aomt_pkg::CmdW-1:0]     cmd_ff;
   aomt_pkg::offs_type            offs_ff;
   aomt_pkg::token_type           tok_ff;
   aomt_pkg::token_type           tok_in_next;
   logic                          hit;
   logic                          take;

   always_comb begin
      hit  = used_ff && tok_in.valid && (id_ff == tok_in.id);
      // Only the first cell matching both id and command takes the activation.
      take = hit && tok_in.command && !tok_in.found && (cmd_ff == tok_in.cmd);

      active_in = active_ff;
      if (hit) begin
         active_in = take;
      end
      if (wr_en) begin
         active_in = 1'b0;
      end
      used_in = used_ff | wr_en;

      tok_in_next       = tok_in;
      tok_in_next.found = tok_in.found | take;
      for (int k = 0; k < aomt_pkg::NumOfs; k++) begin
         if (active_in && (offs_ff[k] > tok_in.maxs[k])) begin
            tok_in_next.maxs[k] = offs_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         active_ff <= 1'b0;
         tok_ff    <= '0;
      end else begin
         used_ff   <= used_in;
         active_ff <= active_in;
         tok_ff    <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_ff   <= wr_data.id;
         cmd_ff  <= wr_data.cmd;
         offs_ff <= wr_data.offs;
      end
   end

   assign tok_out = tok_ff;

endmodule

### rtl/core/active_offset_max_table.sv
// Top level of the active offset maximum table: request control and the row of cells.
//
// Usage. Requests arrive as beats on the req_ch channel and every request gives
// exactly one response beat on the rsp_ch channel, in request order. Each beat
// carries the status, the four current offset totals and the changed and matched
// flags. A load writes the next free cell of the row directly; a full table,
// an unknown actuator id and the unused operation code are answered at once.
// These responses appear in the cycle after the request beat is taken.
// A deactivate or a command launches a token that walks the row of cells, one
// cell per cycle. Each cell clears or takes its active mark as the token passes
// and folds its offsets into the running maxima, so one walk does both the
// matching and the maximum. After the request beat the token passes the launch
// register and every cell register, and FINISH then loads the response register.
// One request is in flight at a time. A new request beat is taken while the
// block is idle and the response register is empty or being emptied in the same
// cycle. When the receiver stalls, the finished response waits in its register
// and the block holds further requests. Reset empties the table, clears all
// active marks and the four totals, and drops any response not yet taken.
module active_offset_max_table (
   input  logic        clock,
   input  logic        reset,
   aomt_req_if.sink    req_ch,
   aomt_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      FINISH
   } state_type;

   state_type                           state_ff;
   logic [aomt_pkg::CountW-1:0]         count_ff;
   aomt_pkg::offs_type                  totals_ff;
   aomt_pkg::token_type                 launch_ff;
   logic                                rsp_valid_ff;
   logic [aomt_pkg::StW-1:0]            rsp_status_ff;
   aomt_pkg::offs_type                  rsp_totals_ff;
   logic                                rsp_changed_ff;
   logic                                rsp_matched_ff;
   logic                                changed_ff;
   logic                                matched_ff;

   aomt_pkg::token_type                 tok_chain [aomt_pkg::TableDepth+1];
   aomt_pkg::entry_type                 load_entry;
   logic                                accept;
   logic                                slot_free;
   logic                                known;
   logic                                full;
   logic                                load_go;

   // The response register is free when empty or emptied at this edge.
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign known = ({1'b0, req_ch.actuator_id} <
                   (aomt_pkg::IdW+1)'(aomt_pkg::NumActuators));
   assign full  = (count_ff == aomt_pkg::CountW'(aomt_pkg::TableDepth));
   assign load_go = accept && (req_ch.op == aomt_pkg::OP_LOAD) && !full && known;

   always_comb begin
      load_entry.id                       = req_ch.actuator_id;
      load_entry.cmd                      = req_ch.command_code;
      load_entry.offs[aomt_pkg::OfsLeft]  = req_ch.left_offset;
      load_entry.offs[aomt_pkg::OfsRight] = req_ch.right_offset;
      load_entry.offs[aomt_pkg::OfsFront] = req_ch.front_offset;
      load_entry.offs[aomt_pkg::OfsBack]  = req_ch.back_offset;
   end

   // The row of cells; the token enters at cell zero and leaves after the last.
   assign tok_chain[0] = launch_ff;

   for (genvar i = 0; i < aomt_pkg::TableDepth; i++) begin : g_cell
      aomt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (load_go && (count_ff == aomt_pkg::CountW'(i))),
         .wr_data (load_entry),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         totals_ff    <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff.valid <= 1'b0;
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            IDLE: begin
               if (accept) begin
                  // Default answer: totals as they stand, no flags.
                  rsp_totals_ff  <= totals_ff;
                  rsp_changed_ff <= 1'b0;
                  rsp_matched_ff <= 1'b0;
                  rsp_status_ff  <= aomt_pkg::ST_OK;
                  case (req_ch.op)
                     aomt_pkg::OP_LOAD: begin
                        rsp_valid_ff <= 1'b1;
                        if (full) begin
                           rsp_status_ff <= aomt_pkg::ST_FULL;
                        end else if (!known) begin
                           rsp_status_ff <= aomt_pkg::ST_UNKNOWN;
                        end else begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     aomt_pkg::OP_DEACT, aomt_pkg::OP_CMD: begin
                        if (!known) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= aomt_pkg::ST_UNKNOWN;
                        end else begin
                           launch_ff.valid   <= 1'b1;
                           launch_ff.command <= (req_ch.op == aomt_pkg::OP_CMD);
                           launch_ff.id      <= req_ch.actuator_id;
                           launch_ff.cmd     <= req_ch.command_code;
                           launch_ff.found   <= 1'b0;
                           launch_ff.maxs    <= '0;
                           state_ff          <= WALK;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end

            WALK: begin
               if (tok_chain[aomt_pkg::TableDepth].valid) begin
                  // A deactivate leaves the totals alone; a command replaces them.
                  if (tok_chain[aomt_pkg::TableDepth].command) begin
                     totals_ff  <= tok_chain[aomt_pkg::TableDepth].maxs;
                     changed_ff <= (tok_chain[aomt_pkg::TableDepth].maxs != totals_ff);
                     matched_ff <= tok_chain[aomt_pkg::TableDepth].found;
                  end else begin
                     changed_ff <= 1'b0;
                     matched_ff <= 1'b0;
                  end
                  state_ff <= FINISH;
               end
            end

            FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= aomt_pkg::ST_OK;
                  rsp_totals_ff  <= totals_ff;
                  rsp_changed_ff <= changed_ff;
                  rsp_matched_ff <= matched_ff;
                  state_ff       <= IDLE;
               end
            end

            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.total_left     = rsp_totals_ff[aomt_pkg::OfsLeft];
   assign rsp_ch.total_right    = rsp_totals_ff[aomt_pkg::OfsRight];
   assign rsp_ch.total_front    = rsp_totals_ff[aomt_pkg::OfsFront];
   assign rsp_ch.total_back     = rsp_totals_ff[aomt_pkg::OfsBack];
   assign rsp_ch.totals_changed = rsp_changed_ff;
   assign rsp_ch.entry_matched  = rsp_matched_ff;

endmodule

### test/tb.sv
// Testbench for the active offset maximum table: directed and random requests checked beat by beat.
`timescale 1ns / 1ps

module tb;
   import aomt_pkg::*;

   // The unused operation code has no name in the package; the block must answer it with OK.
   localparam logic [OpW-1:0] OP_NONE = 2'd3;

   // Cycles after the last response beat before the run is closed, covering one full walk.
   localparam int DrainCycles = TableDepth + 8;

   // One request beat as the sender sees it.
   typedef struct packed {
      logic [OpW-1:0]  op;
      logic [IdW-1:0]  id;
      logic [CmdW-1:0] cmd;
      offs_type        offs;
   } request_type;

   // One response beat, in the field order of the response channel.
   typedef struct packed {
      logic [StW-1:0] status;
      offs_type       totals;
      logic           changed;
      logic           matched;
   } outcome_type;

   logic clock;
   logic reset;

   aomt_req_if req_ch ();
   aomt_rsp_if rsp_ch ();

   active_offset_max_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the table, updated at the moment each request beat is accepted.
   logic [IdW-1:0]  ent_id     [TableDepth];
   logic [CmdW-1:0] ent_cmd    [TableDepth];
   offs_type        ent_offs   [TableDepth];
   bit              ent_active [TableDepth];
   int              fill_count;
   offs_type        max_totals;

   // Responses the block still owes, oldest first.
   outcome_type pending_outcomes[$];

   int error_count;
   // When cleared, neither side inserts gaps, so beats go back to back.
   bit idle_on;
   // A nonzero value makes the receiver hold off that many cycles before its next beat.
   int hold_off_cycles;

   always #10 clock = ~clock;

   // Marks of every entry of this actuator are dropped by deactivate and by command.
   function automatic void clear_marks_of(input logic [IdW-1:0] id);
      int i;
      for (i = 0; i < fill_count; i++) begin
         if (ent_id[i] == id) begin
            ent_active[i] = 1'b0;
         end
      end
   endfunction

   // Applies one accepted request to the shadow table and returns the response it must cause.
   function automatic outcome_type apply_request(input request_type r);
      outcome_type o;
      offs_type    fresh;
      bit          known;
      int          i;
      int          k;
      o = '0;
      known = (r.id < NumActuators);
      case (r.op)
         OP_LOAD: begin
            // Fullness is judged before the id, so a full table hides an unknown id.
            if (fill_count >= TableDepth) begin
               o.status = ST_FULL;
            end else if (!known) begin
               o.status = ST_UNKNOWN;
            end else begin
               ent_id[fill_count]     = r.id;
               ent_cmd[fill_count]    = r.cmd;
               ent_offs[fill_count]   = r.offs;
               ent_active[fill_count] = 1'b0;
               fill_count++;
            end
         end
         OP_DEACT: begin
            // Totals are deliberately left stale after a deactivate.
            if (!known) begin
               o.status = ST_UNKNOWN;
            end else begin
               clear_marks_of(r.id);
            end
         end
         OP_CMD: begin
            if (!known) begin
               o.status = ST_UNKNOWN;
            end else begin
               clear_marks_of(r.id);
               // Only the first entry matching both id and command code is activated.
               for (i = 0; i < fill_count; i++) begin
                  if (!o.matched && ent_id[i] == r.id && ent_cmd[i] == r.cmd) begin
                     ent_active[i] = 1'b1;
                     o.matched = 1'b1;
                  end
               end
               // Totals are the lane-wise maxima over active entries, zero when none is active.
               fresh = '0;
               for (i = 0; i < fill_count; i++) begin
                  if (ent_active[i]) begin
                     for (k = 0; k < NumOfs; k++) begin
                        if (ent_offs[i][k] > fresh[k]) begin
                           fresh[k] = ent_offs[i][k];
                        end
                     end
                  end
               end
               o.changed  = (fresh != max_totals);
               max_totals = fresh;
            end
         end
         default: begin
         end
      endcase
      o.totals = max_totals;
      return o;
   endfunction

   // Offsets with the lane extremes showing up often enough to matter for the maxima.
   function automatic offs_type random_offsets();
      offs_type o;
      int       k;
      for (k = 0; k < NumOfs; k++) begin
         case ($urandom_range(0, 7))
            0:       o[k] = '0;
            1:       o[k] = '1;
            2:       o[k] = OfsW'($urandom_range(0, 255));
            default: o[k] = OfsW'($urandom);
         endcase
      end
      return o;
   endfunction

   // A request against the current table: mostly commands and deactivates aimed at ids and
   // codes that are really stored, with some unknown ids, refused loads and unused codes.
   function automatic request_type random_table_request();
      request_type r;
      int          sel;
      int          pick;
      sel    = $urandom_range(0, 99);
      r.offs = random_offsets();
      r.cmd  = CmdW'($urandom_range(0, 255));
      r.id   = IdW'($urandom_range(0, 63));
      if (sel < 50) begin
         r.op = OP_CMD;
      end else if (sel < 75) begin
         r.op = OP_DEACT;
      end else if (sel < 90) begin
         r.op = OP_LOAD;
      end else begin
         r.op = OP_NONE;
      end
      if (sel < 75 && fill_count > 0 && $urandom_range(0, 9) < 8) begin
         pick = $urandom_range(0, fill_count - 1);
         r.id = ent_id[pick];
         if ($urandom_range(0, 9) < 7) begin
            r.cmd = ent_cmd[pick];
         end
      end
      return r;
   endfunction

   // Offers one request beat, waits for it to be taken and records the response it owes.
   task automatic send_request(input request_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.op           = r.op;
      req_ch.actuator_id  = r.id;
      req_ch.command_code = r.cmd;
      req_ch.left_offset  = r.offs[OfsLeft];
      req_ch.right_offset = r.offs[OfsRight];
      req_ch.front_offset = r.offs[OfsFront];
      req_ch.back_offset  = r.offs[OfsBack];
      do @(posedge clock); while (!req_ch.ready);
      pending_outcomes.push_back(apply_request(r));
   endtask

   task automatic send_fields(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                              input logic [CmdW-1:0] cmd, input offs_type offs);
      request_type r;
      r.op   = op;
      r.id   = id;
      r.cmd  = cmd;
      r.offs = offs;
      send_request(r);
   endtask

   // Empty-table behavior, every operation, the unknown-id rejections, first-match order and the
   // stale totals left behind by a deactivate.
   task automatic test_directed();
      send_fields(OP_CMD, 6'd0, 8'd0, '0);              // command with nothing stored
      send_fields(OP_NONE, 6'd63, 8'hFF, '1);           // unused operation code
      send_fields(OP_LOAD, 6'd32, 8'h01, '1);           // lowest unknown id
      send_fields(OP_DEACT, 6'd63, 8'h00, '0);
      send_fields(OP_CMD, 6'd63, 8'hFF, '0);
      send_fields(OP_LOAD, 6'd0, 8'h00, '0);
      send_fields(OP_LOAD, 6'd31, 8'hFF, '1);
      send_fields(OP_LOAD, 6'd5, 8'hA5, {16'h0001, 16'h8000, 16'h00FF, 16'h1234});
      // Same key again: a command must pick the earlier entry.
      send_fields(OP_LOAD, 6'd5, 8'hA5, {16'hFFFF, 16'h0002, 16'h7FFF, 16'h4321});
      send_fields(OP_LOAD, 6'd5, 8'h5A, {16'h0400, 16'h0300, 16'h0200, 16'h0100});
      send_fields(OP_CMD, 6'd31, 8'hFF, '0);            // totals jump to full scale
      send_fields(OP_CMD, 6'd31, 8'hFF, '0);            // same match, nothing changes
      send_fields(OP_CMD, 6'd5, 8'hA5, '0);
      send_fields(OP_DEACT, 6'd31, 8'h00, '0);          // totals stay as they were
      send_fields(OP_CMD, 6'd5, 8'h5A, '0);             // swap the active entry of id 5
      send_fields(OP_CMD, 6'd0, 8'h00, '0);             // all-zero entry becomes active
      send_fields(OP_CMD, 6'd5, 8'h11, '0);             // no match, but marks still clear
      send_fields(OP_NONE, 6'd21, 8'h5C, random_offsets());
   endtask

   // Loads fill the table from a small pool of ids and codes so that keys repeat, mixed
   // with commands and deactivates, until the table is full.
   task automatic test_fill_table();
      request_type r;
      int          sel;
      while (fill_count < TableDepth) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            r.op   = OP_LOAD;
            r.id   = ($urandom_range(0, 8) == 8) ? IdW'(NumActuators - 1)
                                                 : IdW'($urandom_range(0, 7));
            r.cmd  = ($urandom_range(0, 3) == 0) ? CmdW'($urandom_range(0, 255))
                                                 : CmdW'($urandom_range(0, 3));
            r.offs = random_offsets();
         end else if (sel < 70) begin
            r      = random_table_request();
            r.op   = OP_LOAD;
            r.id   = IdW'($urandom_range(NumActuators, 63));
         end else begin
            r = random_table_request();
         end
         send_request(r);
      end
      // Full table: refused before the id is looked at, known or not.
      send_fields(OP_LOAD, 6'd3, 8'h01, random_offsets());
      send_fields(OP_LOAD, 6'd63, 8'h01, random_offsets());
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_request(random_table_request());
   endtask

   // Both sides drop their gaps so that beats are offered and taken back to back.
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_random_traffic(count);
      idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while requests keep coming without gaps,
   // so the response register fills and the block must stall its request side.
   task automatic test_receiver_hold_off(input int count);
      hold_off_cycles = 400;
      idle_on = 1'b0;
      test_random_traffic(count);
      idle_on = 1'b1;
   endtask

   task automatic check_field(input string name, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, expected,
                  actual);
         error_count++;
      end
   endtask

   // Response side: draws a stall for every beat, then compares the taken beat with the
   // oldest outstanding response.
   initial begin
      outcome_type exp;
      int          stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = idle_on ? $urandom_range(0, 18) : 0;
         end
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_outcomes.size() == 0) begin
            $display("%0t: mismatch in beat count: expected no response beat, actual beat %s%0h",
                     $time, "with status ", rsp_ch.status);
            error_count++;
         end else begin
            exp = pending_outcomes.pop_front();
            check_field("status", exp.status, rsp_ch.status);
            check_field("total_left", exp.totals[OfsLeft], rsp_ch.total_left);
            check_field("total_right", exp.totals[OfsRight], rsp_ch.total_right);
            check_field("total_front", exp.totals[OfsFront], rsp_ch.total_front);
            check_field("total_back", exp.totals[OfsBack], rsp_ch.total_back);
            check_field("totals_changed", exp.changed, rsp_ch.totals_changed);
            check_field("entry_matched", exp.matched, rsp_ch.entry_matched);
         end
         @(negedge clock);
      end
   end

   // Watchdog: far beyond the slowest legal run, which is about two milliseconds.
   initial begin
      #20_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      error_count         = 0;
      idle_on             = 1'b1;
      hold_off_cycles     = 0;
      fill_count          = 0;
      max_totals          = '0;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_LOAD;
      req_ch.actuator_id  = '0;
      req_ch.command_code = '0;
      req_ch.left_offset  = '0;
      req_ch.right_offset = '0;
      req_ch.front_offset = '0;
      req_ch.back_offset  = '0;
      for (int i = 0; i < TableDepth; i++) begin
         ent_active[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_fill_table();
      test_random_traffic(1350);
      test_back_to_back(100);
      test_receiver_hold_off(30);
      test_random_traffic(20);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // Any stray beat after the last expected one is still caught by the response side.
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
